// ===== sv/grs_pkg.sv =====
// Shared types, codes and constants for the GOOSE retransmit scheduler.
// No dependencies; imported by every module of the block except grs_ram.
package grs_pkg;

    localparam int SLOTS_DEFAULT   = 16;
    localparam int BURST_DEFAULT   = 6;
    localparam int FAST_DEFAULT    = 3;
    localparam int LIVE_GROWTH     = 2;   // live time doubles: done as a left shift
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int S_TDATA_W       = 56;
    localparam int M_TDATA_W       = 88;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_REG    = 2'd1,
        ACT_DEREG  = 2'd2,
        ACT_NOTIFY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_TRANSMIT   = 3'd0,
        KIND_REGISTERED = 3'd1,
        KIND_TABLE_FULL = 3'd2,
        KIND_ACK        = 3'd3,
        KIND_TICK_DONE  = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_RELOAD = 1'd0,
        CFG_FAST_LIVE    = 1'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIND,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [3:0]  burst_reload;
        logic [15:0] fast_live;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [3:0]  slot;
        logic        in_range;
        logic [15:0] default_live;
        logic [31:0] start_state;
        logic        start_updated;
    } cmd_t;

    typedef struct packed {
        logic [15:0] default_live;
        logic [15:0] cur_live;
        logic [15:0] ticks;
        logic [3:0]  bursts;
        logic [31:0] state_num;
        logic [31:0] seq_num;
    } slot_entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [31:0] state_num;
        logic [31:0] seq_num;
        logic [15:0] live;
        logic        last;
    } res_t;

endpackage

// ===== sv/grs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-slot timer and counter words.
module grs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/grs_front.sv =====
// Front end: accepts input transfers, decodes them into commands and queues them.
// Depends on grs_pkg.
module grs_front
    import grs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_pop
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              dec;
    logic              push;

    // Decode the transfer; flag slot indexes beyond the table here.
    always_comb begin
        dec.action        = action_t'(s_tuser);
        dec.slot          = s_tdata[3:0];
        dec.in_range      = (32'(s_tdata[3:0]) < 32'(SLOTS));
        dec.default_live  = s_tdata[19:4];
        dec.start_state   = s_tdata[51:20];
        dec.start_updated = s_tdata[52];
    end

    assign s_tready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push    ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== sv/grs_engine.sv =====
// Back end: executes queued commands against the slot table and drives results.
// Depends on grs_pkg and grs_ram.
module grs_engine
    import grs_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEFAULT,
    parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int ENTRY_W = $bits(slot_entry_t);

    eng_state_t         state_reg, state_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [SLOTS-1:0]   pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    res_t               res_reg, res_next;
    logic               out_load;
    logic               out_free;
    logic               idx_last;
    logic [SLOT_W-1:0]  cmd_idx;

    logic               ram_we;
    slot_entry_t        ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_raw;
    slot_entry_t        cur_ent;
    slot_entry_t        svc_ent;
    slot_entry_t        reg_ent;
    logic               svc_xmit;

    grs_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_addr (idx_next),
        .rd_data (ram_rd_raw)
    );

    assign cur_ent  = slot_entry_t'(ram_rd_raw);
    assign out_free = !m_valid_reg || m_tready;
    assign idx_last = (idx_reg == SLOT_W'(SLOTS - 1));
    assign cmd_idx  = SLOT_W'(cmd.slot);

    // Timer service of the visited slot.
    always_comb begin
        svc_ent  = cur_ent;
        svc_xmit = 1'b1;
        if (pend_reg[idx_reg]) begin
            svc_ent.bursts    = cfg.burst_reload;
            svc_ent.cur_live  = cfg.fast_live;
            svc_ent.ticks     = '0;
            svc_ent.state_num = cur_ent.state_num + 32'd1;
            svc_ent.seq_num   = '0;
        end else if (cur_ent.ticks < cur_ent.cur_live) begin
            svc_ent.ticks = cur_ent.ticks + 16'd1;
            svc_xmit      = 1'b0;
        end else begin
            svc_ent.seq_num = cur_ent.seq_num + 32'd1;
            if (cur_ent.bursts != '0) begin
                svc_ent.bursts   = cur_ent.bursts - 4'd1;
                // double and saturate
                svc_ent.cur_live = cur_ent.cur_live[15] ? 16'hFFFF
                                                        : {cur_ent.cur_live[14:0], 1'b0};
            end else begin
                svc_ent.cur_live = cur_ent.default_live;
            end
            svc_ent.ticks = '0;
        end
    end

    always_comb begin
        reg_ent.default_live = cmd.default_live;
        reg_ent.cur_live     = cmd.default_live;
        reg_ent.ticks        = '0;
        reg_ent.bursts       = '0;
        reg_ent.state_num    = cmd.start_state;
        reg_ent.seq_num      = '0;
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        pend_next   = pend_reg;
        res_next    = res_reg;
        out_load    = 1'b0;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_wr_data = svc_ent;

        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (cmd_valid) begin
                    unique case (cmd.action)
                        ACT_TICK: state_next = ST_WALK;
                        ACT_REG:  state_next = ST_FIND;
                        ACT_DEREG, ACT_NOTIFY: begin
                            if (out_free) begin
                                out_load = 1'b1;
                                cmd_pop  = 1'b1;
                                res_next = '{kind: KIND_ACK, slot: cmd.slot, state_num: '0,
                                             seq_num: '0, live: '0, last: 1'b1};
                                if (cmd.in_range) begin
                                    if (cmd.action == ACT_DEREG) begin
                                        valid_next[cmd_idx] = 1'b0;
                                        pend_next[cmd_idx]  = 1'b0;
                                    end else if (valid_reg[cmd_idx]) begin
                                        pend_next[cmd_idx] = 1'b1;
                                    end
                                end
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_WALK: begin
                // Hold on a slot that must transmit while the result slot is busy.
                if (!valid_reg[idx_reg] || !svc_xmit || out_free) begin
                    if (valid_reg[idx_reg]) begin
                        ram_we             = 1'b1;
                        pend_next[idx_reg] = 1'b0;
                        if (svc_xmit) begin
                            out_load = 1'b1;
                            res_next = '{kind: KIND_TRANSMIT, slot: 4'(idx_reg),
                                         state_num: svc_ent.state_num,
                                         seq_num: svc_ent.seq_num,
                                         live: svc_ent.cur_live, last: 1'b0};
                        end
                    end
                    if (idx_last) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_FIND: begin
                if (!valid_reg[idx_reg]) begin
                    if (out_free) begin
                        ram_we              = 1'b1;
                        ram_wr_data         = reg_ent;
                        valid_next[idx_reg] = 1'b1;
                        pend_next[idx_reg]  = cmd.start_updated;
                        out_load            = 1'b1;
                        cmd_pop             = 1'b1;
                        state_next          = ST_IDLE;
                        res_next = '{kind: KIND_REGISTERED, slot: 4'(idx_reg), state_num: '0,
                                     seq_num: '0, live: '0, last: 1'b1};
                    end
                end else if (idx_last) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        cmd_pop    = 1'b1;
                        state_next = ST_IDLE;
                        res_next = '{kind: KIND_TABLE_FULL, slot: '0, state_num: '0,
                                     seq_num: '0, live: '0, last: 1'b1};
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    cmd_pop    = 1'b1;
                    state_next = ST_IDLE;
                    res_next = '{kind: KIND_TICK_DONE, slot: '0, state_num: '0,
                                 seq_num: '0, live: '0, last: 1'b1};
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            valid_reg   <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {4'd0, res_reg.live, res_reg.seq_num, res_reg.state_num, res_reg.slot};

`ifndef SYNTHESIS
    a_ram_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_WALK || state_reg == ST_FIND))
        else $error("slot table written outside a scan");

    a_pop_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (out_load && res_next.last))
        else $error("command retired without its closing result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten before transfer");

    a_idle_table_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !cmd_valid) |=> $stable(valid_reg))
        else $error("slot valid flags changed with no command");
`endif

endmodule

// ===== sv/goose_retransmit_scheduler.sv =====
// Top level of the GOOSE retransmit scheduler: configuration registers and wiring.
// Depends on grs_pkg, grs_front, grs_engine (and grs_ram through the engine).
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: action; tdata: slot, live, state, upd
//  m_       | out       | m_tvalid/m_tready  | tuser: kind; tdata: slot, counters, live; tlast
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// In a tick the slot RAM is visited one entry per cycle through its single read port,
// except while a slot that must transmit is held; then the tick-done result closes the run.
// Register scans for the first free slot; deregister and notify are answered straight
// from idle. A transmitting slot holds the scan while m_tvalid is high and m_tready low.
// Reset (aresetn low, synchronous) clears the valid and change flags at once; no
// clearing pass runs, and RAM words are rewritten whenever a slot is registered.
// A two-entry command queue lets up to two actions wait while the back end is busy;
// s_tready drops once both entries are taken.
module goose_retransmit_scheduler
    import grs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] slot, [19:4] default_live,
                                             // [51:20] start_state_num, [52] start_updated
    input  logic [1:0]            s_tuser,   // [1:0] action
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [3:0] slot_out, [35:4] state_num,
                                             // [67:36] seq_num, [83:68] live_time
    output logic [2:0]            m_tuser,   // [2:0] kind
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [3:0]  burst_reload_reg;
    logic [15:0] fast_live_reg;
    cfg_t        cfg;
    logic        cfg_wr;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;

    // Writes taken every cycle; user must let them arrive only while the block is idle.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reload_reg <= 4'(BURST_DEFAULT);
            fast_live_reg    <= 16'(FAST_DEFAULT);
        end else if (cfg_wr) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BURST_RELOAD: burst_reload_reg <= cfg_data[3:0];
                CFG_FAST_LIVE:    fast_live_reg    <= cfg_data;
                default:          fast_live_reg    <= fast_live_reg;
            endcase
        end
    end

    assign cfg.burst_reload = burst_reload_reg;
    assign cfg.fast_live    = fast_live_reg;

    // Front end: accept and decode transfers into the command queue.
    grs_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: walk the slot table and produce results.
    grs_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== test/goose_retransmit_scheduler_chk.sv =====
`timescale 1ns / 1ps
// Scoreboard for goose_retransmit_scheduler: mirrors the slot table, timers and settings,
// predicts the results of every accepted action and compares the result stream in order.
// Depends on grs_pkg; watches the ports only.
module goose_retransmit_scheduler_chk
    import grs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [2:0]            m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    logic [3:0]  burst_cfg;
    logic [15:0] fast_cfg;

    logic        slot_used        [SLOTS];
    logic        change_flag      [SLOTS];
    logic [15:0] base_live        [SLOTS];
    logic [15:0] live_now         [SLOTS];
    logic [15:0] ticks_waited     [SLOTS];
    logic [3:0]  bursts_remaining [SLOTS];
    logic [31:0] state_cnt        [SLOTS];
    logic [31:0] seq_cnt          [SLOTS];

    res_t due_results[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic res_t make_result(kind_t k, logic [3:0] s, logic [31:0] st,
                                         logic [31:0] sq, logic [15:0] lv, logic lst);
        res_t r;
        r.kind      = k;
        r.slot      = s;
        r.state_num = st;
        r.seq_num   = sq;
        r.live      = lv;
        r.last      = lst;
        return r;
    endfunction

    function automatic void drop_slot(int i);
        slot_used[i]        = 1'b0;
        change_flag[i]      = 1'b0;
        base_live[i]        = '0;
        live_now[i]         = '0;
        ticks_waited[i]     = '0;
        bursts_remaining[i] = '0;
        state_cnt[i]        = '0;
        seq_cnt[i]          = '0;
    endfunction

    // Advance one slot's retransmit timer; true when it sends on this tick.
    function automatic bit slot_fires(int i);
        logic [16:0] doubled;
        if (change_flag[i]) begin
            change_flag[i]      = 1'b0;
            bursts_remaining[i] = burst_cfg;
            live_now[i]         = fast_cfg;
            ticks_waited[i]     = '0;
            state_cnt[i]        = state_cnt[i] + 32'd1;
            seq_cnt[i]          = '0;
            return 1'b1;
        end
        if (ticks_waited[i] < live_now[i]) begin
            ticks_waited[i] = ticks_waited[i] + 16'd1;
            return 1'b0;
        end
        seq_cnt[i] = seq_cnt[i] + 32'd1;
        if (bursts_remaining[i] != 4'd0) begin
            doubled             = 17'({1'b0, live_now[i]} * LIVE_GROWTH);
            bursts_remaining[i] = bursts_remaining[i] - 4'd1;
            live_now[i]         = doubled[16] ? 16'hFFFF : doubled[15:0];
        end else begin
            live_now[i] = base_live[i];
        end
        ticks_waited[i] = '0;
        return 1'b1;
    endfunction

    function automatic void schedule_action(action_t act, logic [3:0] slot, logic [15:0] live,
                                            logic [31:0] st, logic upd);
        bit placed;
        placed = 1'b0;
        case (act)
            ACT_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        if (slot_fires(i)) begin
                            due_results.push_back(make_result(KIND_TRANSMIT, i[3:0],
                                state_cnt[i], seq_cnt[i], live_now[i], 1'b0));
                        end
                    end
                end
                due_results.push_back(make_result(KIND_TICK_DONE, '0, '0, '0, '0, 1'b1));
            end
            ACT_REG: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!placed && !slot_used[i]) begin
                        drop_slot(i);
                        slot_used[i]   = 1'b1;
                        change_flag[i] = upd;
                        base_live[i]   = live;
                        live_now[i]    = live;
                        state_cnt[i]   = st;
                        placed         = 1'b1;
                        due_results.push_back(make_result(KIND_REGISTERED, i[3:0],
                            '0, '0, '0, 1'b1));
                    end
                end
                if (!placed)
                    due_results.push_back(make_result(KIND_TABLE_FULL, '0, '0, '0, '0, 1'b1));
            end
            default: begin
                if (int'(slot) < SLOTS) begin
                    if (act == ACT_DEREG)
                        drop_slot(int'(slot));
                    else if (slot_used[slot])
                        change_flag[slot] = 1'b1;
                end
                due_results.push_back(make_result(KIND_ACK, slot, '0, '0, '0, 1'b1));
            end
        endcase
    endfunction

    function automatic void check_result(res_t got);
        res_t want;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result kind=%0d slot=%0d st=%0h sq=%0h live=%0h last=%0b",
                         $time, got.kind, got.slot, got.state_num, got.seq_num, got.live,
                         got.last);
            return;
        end
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot
            || got.state_num !== want.state_num || got.seq_num !== want.seq_num
            || got.live !== want.live || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result mismatch", $time);
                $display("  expected kind=%0d slot=%0d st=%0h sq=%0h live=%0h last=%0b",
                         want.kind, want.slot, want.state_num, want.seq_num, want.live,
                         want.last);
                $display("  actual   kind=%0d slot=%0d st=%0h sq=%0h live=%0h last=%0b",
                         got.kind, got.slot, got.state_num, got.seq_num, got.live, got.last);
            end
        end
    endfunction

    always @(posedge aclk) begin
        res_t got;
        if (!aresetn) begin
            burst_cfg = BURST_DEFAULT[3:0];
            fast_cfg  = FAST_DEFAULT[15:0];
            for (int i = 0; i < SLOTS; i++)
                drop_slot(i);
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BURST_RELOAD)
                    burst_cfg = cfg_data[3:0];
                else if (cfg_index == CFG_FAST_LIVE)
                    fast_cfg = cfg_data;
            end
            // Predict before checking: a result never leaves in the cycle its action enters.
            if (s_tvalid && s_tready)
                schedule_action(action_t'(s_tuser), s_tdata[3:0], s_tdata[19:4],
                                s_tdata[51:20], s_tdata[52]);
            if (m_tvalid && m_tready) begin
                got.kind      = kind_t'(m_tuser);
                got.slot      = m_tdata[3:0];
                got.state_num = m_tdata[35:4];
                got.seq_num   = m_tdata[67:36];
                got.live      = m_tdata[83:68];
                got.last      = m_tlast;
                check_result(got);
            end
        end
        outstanding <= due_results.size();
    end

endmodule

// ===== test/goose_retransmit_scheduler_tb.sv =====
`timescale 1ns / 1ps
// Top of the goose_retransmit_scheduler regression: clock, reset, action stimulus,
// result back-pressure, settings writes and the verdict. Depends on grs_pkg, the block
// and goose_retransmit_scheduler_chk, which does all prediction and comparison.
module goose_retransmit_scheduler_tb;
    import grs_pkg::*;

    localparam int QUIET_LIMIT = 5000;   // cycles without any transfer before giving up
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off that backs up the input
    localparam int END_PAUSE   = 40;     // pause after the final drain before the verdict

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [3:0] slot, [19:4] default_live,
                                             // [51:20] start_state_num, [52] start_updated
    logic [1:0]            s_tuser   = '0;   // [1:0] action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [3:0] slot_out, [35:4] state_num,
                                             // [67:36] seq_num, [83:68] live_time
    logic [2:0]            m_tuser;          // [2:0] kind
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int chk_mismatches;
    int chk_outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_armed     = 1'b0;
    int quiet_cycles   = 0;

    goose_retransmit_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    goose_retransmit_scheduler_chk chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (chk_mismatches),
        .outstanding (chk_outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result receiver: random stalls at the phase's rate; an armed hold keeps tready low
    // for a long stretch so results back up into the block and it stops taking actions.
    always @(posedge aclk) begin
        if (hold_armed) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("goose_retransmit_scheduler regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one action and hold it until the transfer; tvalid stays high on return so
    // back-to-back actions need no gap.
    task automatic send_action(action_t act, logic [3:0] slot, logic [15:0] live,
                               logic [31:0] st, logic upd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, upd, st, live, slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait for every predicted result to be transferred.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chk_outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_setting(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random action: ticks dominate so timers run through bursts into the steady rate;
    // live times are mostly short so retransmissions actually come due.
    task automatic send_random_action;
        int          pick;
        action_t     act;
        logic [15:0] live;
        logic [31:0] st;
        pick = $urandom_range(99);
        if (pick < 40)
            act = ACT_TICK;
        else if (pick < 58)
            act = ACT_REG;
        else if (pick < 75)
            act = ACT_DEREG;
        else
            act = ACT_NOTIFY;
        case ($urandom_range(9))
            0:       live = 16'($urandom);
            1:       live = 16'hFFFF;
            default: live = 16'($urandom_range(0, 5));
        endcase
        if ($urandom_range(3) == 0)
            st = 32'hFFFF_FFFF - $urandom_range(0, 3);   // near the counter wrap
        else
            st = $urandom;
        send_action(act, 4'($urandom_range(0, 15)), live, st, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(int items, int idle_pct, int stall_pct, logic [3:0] burst,
                             logic [15:0] fast, bit squeeze);
        drain();
        write_setting(CFG_BURST_RELOAD, {12'd0, burst});
        write_setting(CFG_FAST_LIVE, fast);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (squeeze)
            hold_armed = 1'b1;
        repeat (items)
            send_random_action();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: short bursts so the fast retransmissions show up within a few ticks.
        write_setting(CFG_BURST_RELOAD, 16'd2);
        write_setting(CFG_FAST_LIVE, 16'd1);
        send_action(ACT_TICK, 4'd0, 16'h0000, 32'h0, 1'b0);             // empty table
        send_action(ACT_REG, 4'd0, 16'h0000, 32'hFFFF_FFFF, 1'b1);     // wraps on first send
        send_action(ACT_REG, 4'd15, 16'hFFFF, 32'h0000_0000, 1'b0);
        send_action(ACT_NOTIFY, 4'd1, 16'h0, 32'h0, 1'b0);
        send_action(ACT_NOTIFY, 4'd15, 16'h0, 32'h0, 1'b0);            // free slot
        send_action(ACT_TICK, 4'd0, 16'h0, 32'h0, 1'b0);
        send_action(ACT_DEREG, 4'd15, 16'h0, 32'h0, 1'b0);             // already free
        repeat (2)
            send_action(ACT_TICK, 4'd0, 16'h0, 32'h0, 1'b0);
        for (int i = 2; i < 16; i++)
            send_action(ACT_REG, 4'd0, 16'(i - 2), 32'(i * 1000), 1'(i));
        send_action(ACT_REG, 4'd0, 16'd7, 32'd7, 1'b1);                 // table full
        send_action(ACT_DEREG, 4'd0, 16'h0, 32'h0, 1'b0);
        send_action(ACT_TICK, 4'd0, 16'h0, 32'h0, 1'b0);                // all 16 slots walked, 15 in use

        // Random phases, each under its own settings, with varying idling patterns.
        run_phase(72, 0,  0,  4'd0,  16'd0,     1'b0);
        run_phase(72, 76, 0,  4'd15, 16'd1,     1'b0);
        run_phase(72, 0,  76, 4'd3,  16'd2,     1'b0);
        run_phase(72, 15, 15, 4'd6,  16'hFFFF,  1'b0);
        run_phase(72, 0,  0,  4'd1,  16'd4,     1'b1);
        run_phase(72, 15, 15, 4'd15, 16'd0,     1'b0);

        drain();
        repeat (END_PAUSE) @(posedge aclk);
        if (chk_mismatches == 0)
            $display("goose_retransmit_scheduler regression: pass");
        else
            $display("goose_retransmit_scheduler regression: fail");
        $finish;
    end

endmodule
